// File: rtl/pts_pkg.sv
// Package for the priority thread scheduler core.
// Holds the command codes, the sequencer state type and the control struct broadcast to the slot cells.
// No dependencies.
package pts_pkg;

	localparam int SLOT_FIELD_W = 5;
	localparam int CMD_W        = 3;
	localparam int TICKS_FIELD_W = 32;
	localparam int IN_DATA_W    = 40;
	localparam int OUT_DATA_W   = 72;
	localparam int MASK_FIELD_W = 31;

	typedef enum logic [CMD_W-1:0] {
		CMD_CREATE = 3'd0,
		CMD_DELAY  = 3'd1,
		CMD_TICK   = 3'd2,
		CMD_SCHED  = 3'd3,
		CMD_SWDONE = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	// Control broadcast to every slot cell for one accepted transfer.
	typedef struct packed {
		logic                    create_en;
		logic                    delay_en;
		logic                    tick_en;
		logic [SLOT_FIELD_W-1:0] target;
	} cell_ctrl_t;

endpackage

// File: rtl/priority_thread_scheduler_core.sv
// Top level of the fixed-priority thread scheduler: command decode, sequencer,
// the row of slot cells and the result register.
// Depends on pts_pkg and pts_slot_cell.
//
// Channel | Direction | Payload
// s_*     | in        | command, slot, delay_ticks
// m_*     | out       | next_slot, next_valid, switch_request, create_accepted,
//         |           | ready_set, delayed_set
//
// Create, tick, switch done, an ignored delay and unknown commands go from accept
// straight to the result load.
// Schedule and an effective delay run a search between accept and the result load.
// The search chain carries the highest ready slot up one slot cell register at a time
// to its top cell, which is read once the whole chain has been walked.
// Reset clears all slots and masks; no thread is current or chosen.
// The next command is taken while a result still waits; a stalled result holds
// the sequencer in its result state until the transfer completes.
module priority_thread_scheduler_core #(
	parameter int SLOT_COUNT   = 32,
	parameter int TIMEOUT_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [2:0] command, [7:3] slot, [39:8] delay_ticks
	input  logic [pts_pkg::IN_DATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [4:0] next_slot, [5] next_valid, [6] switch_request, [7] create_accepted,
	// [38:8] ready_set, [69:39] delayed_set, [71:70] zero
	output logic [pts_pkg::OUT_DATA_W-1:0] m_tdata
);
	import pts_pkg::*;

	localparam int SLOT_W = $clog2(SLOT_COUNT);
	localparam int CNT_W  = $clog2(SLOT_COUNT);

	state_t                    state_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      present0_q;
	logic [SLOT_W-1:0]         cur_q;
	logic                      cur_valid_q;
	logic [SLOT_W-1:0]         chosen_q;
	logic                      chosen_valid_q;
	logic                      sw_q;
	logic                      acc_q;
	logic                      m_tvalid_q;
	logic [OUT_DATA_W-1:0]     m_tdata_q;

	cmd_t                      cmd;
	logic [SLOT_FIELD_W-1:0]   slot_in;
	logic [TIMEOUT_BITS-1:0]   ticks;
	logic                      accept;
	logic                      slot_ok;
	logic                      create_hit;
	logic                      delay_ok;
	logic                      out_free;
	logic [SLOT_W-1:0]         pick;
	cell_ctrl_t                ctrl;

	logic [SLOT_COUNT-1:0]     present_vec;
	logic [SLOT_COUNT-2:0]     ready_vec;
	logic [SLOT_COUNT-2:0]     delayed_vec;
	logic [SLOT_W-1:0]         best_w [SLOT_COUNT];

	assign cmd      = cmd_t'(s_tdata[CMD_W-1:0]);
	assign slot_in  = s_tdata[CMD_W +: SLOT_FIELD_W];
	assign ticks    = s_tdata[CMD_W + SLOT_FIELD_W +: TIMEOUT_BITS];
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign slot_ok    = ({1'b0, slot_in} < (SLOT_FIELD_W + 1)'(SLOT_COUNT));
	assign create_hit = accept && (cmd == CMD_CREATE) && slot_ok
		&& !present_vec[slot_in[SLOT_W-1:0]];
	assign delay_ok   = cur_valid_q && (cur_q != '0);

	always_comb begin
		ctrl.create_en = create_hit;
		ctrl.delay_en  = accept && (cmd == CMD_DELAY) && delay_ok;
		ctrl.tick_en   = accept && (cmd == CMD_TICK);
		ctrl.target    = (cmd == CMD_CREATE) ? slot_in : SLOT_FIELD_W'(cur_q);
	end

	assign best_w[0]      = '0;
	assign present_vec[0] = present0_q;

	for (genvar n = 1; n < SLOT_COUNT; n++) begin : g_cell
		pts_slot_cell #(
			.SLOT_W       (SLOT_W),
			.TIMEOUT_BITS (TIMEOUT_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.ticks    (ticks),
			.slot_id  (SLOT_W'(n)),
			.best_in  (best_w[n-1]),
			.best_out (best_w[n]),
			.present  (present_vec[n]),
			.ready    (ready_vec[n-1]),
			.delayed  (delayed_vec[n-1])
		);
	end

	assign pick = best_w[SLOT_COUNT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			present0_q     <= 1'b0;
			cur_q          <= '0;
			cur_valid_q    <= 1'b0;
			chosen_q       <= '0;
			chosen_valid_q <= 1'b0;
			sw_q           <= 1'b0;
			acc_q          <= 1'b0;
			m_tvalid_q     <= 1'b0;
		end else begin
			if (create_hit && (slot_in == '0)) begin
				present0_q <= 1'b1;
			end
			if ((state_q == ST_EMIT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						acc_q <= create_hit;
						sw_q  <= 1'b0;
						cnt_q <= '0;
						unique case (cmd)
							CMD_SCHED: begin
								state_q <= ST_SCAN;
							end
							CMD_DELAY: begin
								state_q <= delay_ok ? ST_SCAN : ST_EMIT;
							end
							CMD_SWDONE: begin
								if (chosen_valid_q) begin
									cur_q       <= chosen_q;
									cur_valid_q <= 1'b1;
								end
								state_q <= ST_EMIT;
							end
							default: begin
								state_q <= ST_EMIT;
							end
						endcase
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + CNT_W'(1);
					// The top cell holds the settled choice once the chain has been fully walked.
					if (cnt_q == CNT_W'(SLOT_COUNT - 1)) begin
						chosen_q       <= pick;
						chosen_valid_q <= present_vec[pick];
						sw_q           <= present_vec[pick] && (!cur_valid_q || (cur_q != pick));
						state_q        <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && out_free) begin
			m_tdata_q <= {2'b00,
				MASK_FIELD_W'(delayed_vec),
				MASK_FIELD_W'(ready_vec),
				acc_q,
				sw_q,
				chosen_valid_q,
				SLOT_FIELD_W'(chosen_q)};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// A slot is never ready and delayed at once.
	a_masks_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		(ready_vec & delayed_vec) == '0)
		else $error("slot both ready and delayed");

	// The current thread always occupies its slot.
	a_current_present: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> present_vec[cur_q])
		else $error("current thread not present");

	// A switch request is only reported for a chosen slot that holds a thread.
	a_switch_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[6]) |-> m_tdata[5])
		else $error("switch request without valid choice");

	// Commands that need no search go straight to the result state.
	a_direct_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd != CMD_SCHED) && (cmd != CMD_DELAY)) |=> (state_q == ST_EMIT))
		else $error("short command did not go to result state");

endmodule

// File: rtl/pts_slot_cell.sv
// One priority slot of the scheduler: presence, ready, delayed, timeout counter,
// and one stage of the highest-ready search chain.
// Depends on pts_pkg.
module pts_slot_cell #(
	parameter int SLOT_W       = 5,
	parameter int TIMEOUT_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pts_pkg::cell_ctrl_t       ctrl,
	input  logic [TIMEOUT_BITS-1:0]   ticks,
	input  logic [SLOT_W-1:0]         slot_id,
	input  logic [SLOT_W-1:0]         best_in,
	output logic [SLOT_W-1:0]         best_out,
	output logic                      present,
	output logic                      ready,
	output logic                      delayed
);
	import pts_pkg::*;

	logic                    present_q;
	logic                    ready_q;
	logic                    delayed_q;
	logic [TIMEOUT_BITS-1:0] timeout_q;
	logic [SLOT_W-1:0]       best_q;
	logic                    hit;
	logic                    count_live;

	assign hit        = (ctrl.target == SLOT_FIELD_W'(slot_id));
	assign count_live = delayed_q && (timeout_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= 1'b0;
			ready_q   <= 1'b0;
			delayed_q <= 1'b0;
			timeout_q <= '0;
			best_q    <= '0;
		end else begin
			priority if (ctrl.create_en && hit && !present_q) begin
				present_q <= 1'b1;
				ready_q   <= 1'b1;
			end else if (ctrl.delay_en && hit) begin
				timeout_q <= ticks;
				ready_q   <= 1'b0;
				delayed_q <= 1'b1;
			end else if (ctrl.tick_en && count_live) begin
				timeout_q <= timeout_q - TIMEOUT_BITS'(1);
				if (timeout_q == TIMEOUT_BITS'(1)) begin
					ready_q   <= 1'b1;
					delayed_q <= 1'b0;
				end
			end
			// Each cell passes the highest ready slot seen so far one step up the row.
			best_q <= ready_q ? slot_id : best_in;
		end
	end

	assign best_out = best_q;
	assign present  = present_q;
	assign ready    = ready_q;
	assign delayed  = delayed_q;

endmodule

// File: tb/priority_thread_scheduler_core_tb.sv
// Self-checking testbench for priority_thread_scheduler_core: directed table, then random traffic.
// Every transfer out is checked against a fixed table entry or the scheduler model in this file.
// Depends on pts_pkg and the RTL of priority_thread_scheduler_core.
`timescale 1ns / 100ps

module priority_thread_scheduler_core_tb;
	import pts_pkg::*;

	localparam int SLOTS       = 32;
	localparam int TICK_BITS   = 32;
	localparam int RANDOM_CMDS = 1800;
	localparam int DRAIN_CYCLES = SLOTS + 8;
	localparam logic [CMD_W-1:0] CMD_BAD_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_BAD_LAST  = 3'd7;

	// Result layout, highest bits first, as carried on m_tdata.
	typedef struct packed {
		logic [1:0]              pad;
		logic [MASK_FIELD_W-1:0] delayed_set;
		logic [MASK_FIELD_W-1:0] ready_set;
		logic                    create_accepted;
		logic                    switch_request;
		logic                    next_valid;
		logic [SLOT_FIELD_W-1:0] next_slot;
	} sched_result_t;

	typedef struct {
		logic [CMD_W-1:0]         op;
		logic [SLOT_FIELD_W-1:0]  slot;
		logic [TICKS_FIELD_W-1:0] ticks;
		bit                       fixed;
		sched_result_t            fixed_res;
	} cmd_row_t;

	typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	// Scheduler model state.
	logic [SLOTS-1:0]        thread_present;
	logic [MASK_FIELD_W-1:0] ready_bits;
	logic [MASK_FIELD_W-1:0] delayed_bits;
	logic [TICK_BITS-1:0]    ticks_left [SLOTS];
	logic [SLOT_FIELD_W-1:0] run_slot;
	bit                      run_valid;
	logic [SLOT_FIELD_W-1:0] pick_slot;
	bit                      pick_valid;

	sched_result_t pending_results[$];
	cmd_row_t      directed_rows[$];

	int fail_count;
	int cmds_sent;
	int results_checked;
	int switches_seen;
	int creates_taken;
	int delays_applied;
	int burst_left;

	rx_mode_t rx_mode;
	int       rx_left;
	int       rx_phase;

	priority_thread_scheduler_core #(
		.SLOT_COUNT(SLOTS),
		.TIMEOUT_BITS(TICK_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Picks the highest ready slot, or the idle slot, and says whether a switch is due.
	function automatic bit pick_highest_ready();
		logic [SLOT_FIELD_W-1:0] pick;
		pick = '0;
		for (int n = 0; n < MASK_FIELD_W; n++)
			if (ready_bits[n])
				pick = SLOT_FIELD_W'(n + 1);
		pick_slot = pick;
		pick_valid = thread_present[pick];
		return pick_valid && (!run_valid || run_slot != pick);
	endfunction

	function automatic sched_result_t apply_command(input logic [CMD_W-1:0] op,
			input logic [SLOT_FIELD_W-1:0] slot, input logic [TICKS_FIELD_W-1:0] ticks);
		sched_result_t res;
		bit sw;
		bit taken;
		sw = 1'b0;
		taken = 1'b0;
		case (op)
			CMD_CREATE: begin
				if (!thread_present[slot]) begin
					thread_present[slot] = 1'b1;
					if (slot != 0)
						ready_bits[slot - 1] = 1'b1;
					taken = 1'b1;
				end
			end
			CMD_DELAY: begin
				if (run_valid && run_slot != 0) begin
					ticks_left[run_slot] = ticks[TICK_BITS-1:0];
					ready_bits[run_slot - 1] = 1'b0;
					delayed_bits[run_slot - 1] = 1'b1;
					sw = pick_highest_ready();
					delays_applied++;
				end
			end
			CMD_TICK: begin
				// A zero timeout is never counted, so such a thread stays delayed.
				for (int i = 1; i < SLOTS; i++) begin
					if (delayed_bits[i-1] && ticks_left[i] != 0) begin
						ticks_left[i] = ticks_left[i] - 1'b1;
						if (ticks_left[i] == 0) begin
							ready_bits[i-1] = 1'b1;
							delayed_bits[i-1] = 1'b0;
						end
					end
				end
			end
			CMD_SCHED: sw = pick_highest_ready();
			CMD_SWDONE: begin
				if (pick_valid) begin
					run_slot = pick_slot;
					run_valid = 1'b1;
				end
			end
			default: ;
		endcase
		if (taken)
			creates_taken++;
		res = '0;
		res.next_slot = pick_slot;
		res.next_valid = pick_valid;
		res.switch_request = sw;
		res.create_accepted = taken;
		res.ready_set = ready_bits;
		res.delayed_set = delayed_bits;
		return res;
	endfunction

	function automatic sched_result_t known_result(input logic [SLOT_FIELD_W-1:0] slot,
			input bit valid, input bit sw, input bit taken,
			input logic [MASK_FIELD_W-1:0] rdy, input logic [MASK_FIELD_W-1:0] dly);
		sched_result_t res;
		res = '0;
		res.next_slot = slot;
		res.next_valid = valid;
		res.switch_request = sw;
		res.create_accepted = taken;
		res.ready_set = rdy;
		res.delayed_set = dly;
		return res;
	endfunction

	task automatic add_row(input logic [CMD_W-1:0] op, input logic [SLOT_FIELD_W-1:0] slot,
			input logic [TICKS_FIELD_W-1:0] ticks, input bit fixed, input sched_result_t res);
		cmd_row_t row;
		row.op = op;
		row.slot = slot;
		row.ticks = ticks;
		row.fixed = fixed;
		row.fixed_res = res;
		directed_rows.push_back(row);
	endtask

	// Drives one command, waits for its transfer and records what must come back.
	task automatic send_cmd(input logic [CMD_W-1:0] op, input logic [SLOT_FIELD_W-1:0] slot,
			input logic [TICKS_FIELD_W-1:0] ticks, input bit fixed, input sched_result_t fixed_res);
		sched_result_t predicted;
		s_tdata <= {ticks, slot, op};
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		predicted = apply_command(op, slot, ticks);
		pending_results.push_back(fixed ? fixed_res : predicted);
		cmds_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 12);
		end
	endtask

	function automatic logic [TICKS_FIELD_W-1:0] random_delay();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 2)
			return '0;
		if (roll < 4)
			return $urandom;
		if (roll < 12)
			return $urandom_range(7, 40);
		return $urandom_range(1, 6);
	endfunction

	// Receiver readiness follows one of several stall patterns that change now and then.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_mode <= RX_OPEN;
			rx_left <= 0;
			rx_phase <= 0;
		end else begin
			rx_phase <= rx_phase + 1;
			if (rx_left == 0) begin
				rx_mode <= rx_mode_t'($urandom_range(0, 3));
				rx_left <= $urandom_range(40, 300);
			end else begin
				rx_left <= rx_left - 1;
			end
			case (rx_mode)
				RX_OPEN:  m_tready <= 1'b1;
				RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
				RX_HEAVY: m_tready <= ($urandom_range(0, 3) == 0);
				default:  m_tready <= (rx_phase % 7) < 3;
			endcase
		end
	end

	always @(posedge clk) begin : result_check
		sched_result_t got;
		sched_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: result transfer with nothing outstanding: %h", $realtime, got);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (got.switch_request)
					switches_seen++;
				if (got.next_slot !== want.next_slot || got.next_valid !== want.next_valid
						|| got.switch_request !== want.switch_request
						|| got.create_accepted !== want.create_accepted
						|| got.ready_set !== want.ready_set
						|| got.delayed_set !== want.delayed_set || got.pad !== want.pad) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("%0t: result %0d mismatch", $realtime, results_checked);
						$display("  expected slot %0d valid %b sw %b acc %b ready %h delayed %h",
							want.next_slot, want.next_valid, want.switch_request,
							want.create_accepted, want.ready_set, want.delayed_set);
						$display("  actual   slot %0d valid %b sw %b acc %b ready %h delayed %h pad %b",
							got.next_slot, got.next_valid, got.switch_request,
							got.create_accepted, got.ready_set, got.delayed_set, got.pad);
					end
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("Timeout with %0d results outstanding", pending_results.size());
		$display("** priority_thread_scheduler_core: FAILED **");
		$finish;
	end

	initial begin
		int scenario;
		int n_directed;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		thread_present = '0;
		ready_bits = '0;
		delayed_bits = '0;
		foreach (ticks_left[i])
			ticks_left[i] = '0;
		run_slot = '0;
		run_valid = 1'b0;
		pick_slot = '0;
		pick_valid = 1'b0;
		fail_count = 0;
		cmds_sent = 0;
		results_checked = 0;
		switches_seen = 0;
		creates_taken = 0;
		delays_applied = 0;
		burst_left = 6;

		// Empty scheduler: unknown code and switch done with nothing chosen, a schedule that
		// finds no thread, a delay and a tick, then the idle thread and slot 31.
		add_row(CMD_BAD_FIRST, 5'd3, 32'hFFFF_FFFF, 1, known_result(0, 0, 0, 0, '0, '0));
		add_row(CMD_SWDONE, 5'd0, 32'h0, 1, known_result(0, 0, 0, 0, '0, '0));
		add_row(CMD_SCHED, 5'd31, 32'h0, 1, known_result(0, 0, 0, 0, '0, '0));
		add_row(CMD_DELAY, 5'd0, 32'd5, 1, known_result(0, 0, 0, 0, '0, '0));
		add_row(CMD_TICK, 5'd0, 32'h0, 1, known_result(0, 0, 0, 0, '0, '0));
		add_row(CMD_CREATE, 5'd0, 32'h0, 1, known_result(0, 0, 0, 1, '0, '0));
		add_row(CMD_CREATE, 5'd0, 32'h0, 1, known_result(0, 0, 0, 0, '0, '0));
		add_row(CMD_SCHED, 5'd0, 32'h0, 1, known_result(0, 1, 1, 0, '0, '0));
		add_row(CMD_SWDONE, 5'd0, 32'h0, 1, known_result(0, 1, 0, 0, '0, '0));
		add_row(CMD_DELAY, 5'd0, 32'd5, 1, known_result(0, 1, 0, 0, '0, '0));
		add_row(CMD_CREATE, 5'd31, 32'h0, 1, known_result(0, 1, 0, 1, 31'h4000_0000, '0));
		add_row(CMD_CREATE, 5'd31, 32'h0, 1, known_result(0, 1, 0, 0, 31'h4000_0000, '0));
		// From here the model supplies the expectation.
		add_row(CMD_CREATE, 5'd1, 32'h0, 0, '0);
		add_row(CMD_SCHED, 5'd0, 32'h0, 0, '0);
		add_row(CMD_SWDONE, 5'd0, 32'h0, 0, '0);
		add_row(CMD_DELAY, 5'd0, 32'hFFFF_FFFF, 0, '0);
		add_row(CMD_SWDONE, 5'd0, 32'h0, 0, '0);
		add_row(CMD_DELAY, 5'd0, 32'h0, 0, '0);
		add_row(CMD_TICK, 5'd31, 32'hFFFF_FFFF, 0, '0);
		add_row(CMD_BAD_LAST, 5'd31, 32'h0, 0, '0);
		add_row(CMD_SWDONE, 5'd0, 32'h0, 0, '0);
		add_row(CMD_CREATE, 5'd16, 32'hFFFF_FFFF, 0, '0);
		add_row(CMD_SCHED, 5'd0, 32'h0, 0, '0);
		add_row(CMD_SWDONE, 5'd0, 32'h0, 0, '0);
		add_row(CMD_DELAY, 5'd0, 32'd2, 0, '0);
		add_row(CMD_TICK, 5'd0, 32'h0, 0, '0);
		add_row(CMD_TICK, 5'd0, 32'h0, 0, '0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_cmd(directed_rows[i].op, directed_rows[i].slot, directed_rows[i].ticks,
				directed_rows[i].fixed, directed_rows[i].fixed_res);
		n_directed = cmds_sent;

		// Mostly well-formed scheduler traffic, with some noise commands mixed in.
		while (cmds_sent < n_directed + RANDOM_CMDS) begin
			scenario = $urandom_range(0, 99);
			if (scenario < 12) begin
				send_cmd(CMD_CREATE, SLOT_FIELD_W'($urandom_range(0, SLOTS - 1)), $urandom,
					0, '0);
				send_cmd(CMD_SCHED, SLOT_FIELD_W'($urandom), $urandom, 0, '0);
				send_cmd(CMD_SWDONE, SLOT_FIELD_W'($urandom), $urandom, 0, '0);
			end else if (scenario < 40) begin
				send_cmd(CMD_DELAY, SLOT_FIELD_W'($urandom), random_delay(), 0, '0);
				send_cmd(CMD_SWDONE, SLOT_FIELD_W'($urandom), $urandom, 0, '0);
			end else if (scenario < 70) begin
				repeat ($urandom_range(1, 5))
					send_cmd(CMD_TICK, SLOT_FIELD_W'($urandom), $urandom, 0, '0);
				send_cmd(CMD_SCHED, SLOT_FIELD_W'($urandom), $urandom, 0, '0);
				send_cmd(CMD_SWDONE, SLOT_FIELD_W'($urandom), $urandom, 0, '0);
			end else if (scenario < 85) begin
				send_cmd(CMD_SCHED, SLOT_FIELD_W'($urandom), $urandom, 0, '0);
				send_cmd(CMD_SWDONE, SLOT_FIELD_W'($urandom), $urandom, 0, '0);
			end else begin
				send_cmd(CMD_W'($urandom_range(0, 7)), SLOT_FIELD_W'($urandom), $urandom,
					0, '0);
			end
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d commands (%0d from the directed table) and checked %0d results.",
			cmds_sent, n_directed, results_checked);
		$display("Seen %0d switch requests, %0d threads created and %0d delays applied.",
			switches_seen, creates_taken, delays_applied);
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("** priority_thread_scheduler_core: PASSED **");
		end else begin
			$display("%0d failures, %0d results missing", fail_count, pending_results.size());
			$display("** priority_thread_scheduler_core: FAILED **");
		end
		$finish;
	end

endmodule
